// ===== hw/rtl/periodic_marker_alignment_check_macros.svh =====
// assertion macros used by the checker file pmac_checker.sv
`ifndef PERIODIC_MARKER_ALIGNMENT_CHECK_MACROS_SVH
`define PERIODIC_MARKER_ALIGNMENT_CHECK_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PMAC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmac check failed");

// antecedent implies consequent in the next cycle
`define PMAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmac check failed");

`endif

// ===== hw/rtl/pmac_pkg.sv =====
// package: widths, reset values, register codes and shared types
`default_nettype none

package pmac_pkg;

   localparam int WORD_W    = 32;
   localparam int PERIOD_W  = 16;
   localparam int CNT_W     = 21;
   localparam int MAX_WORDS = 1048576;

   localparam logic [CNT_W-1:0]    LAST_INDEX   = CNT_W'(MAX_WORDS - 1);
   localparam logic [WORD_W-1:0]   MASK_RESET   = WORD_W'(1);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(3564);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_MASK  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORBIT_PERIOD = 1'b1;

   typedef struct packed {
      logic             done;
      logic             marker_found;
      logic [CNT_W-1:0] first_offset;
      logic [CNT_W-1:0] mismatch_count;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pmac_channels.sv =====
// channel interfaces: snapshot words, results and configuration writes
`default_nettype none

interface pmac_req_if;
   logic                        valid;
   logic                        ready;
   logic [pmac_pkg::WORD_W-1:0] sample_word;
   logic                        last_word;
   modport source (output valid, sample_word, last_word, input ready);
   modport sink   (input valid, sample_word, last_word, output ready);
endinterface

interface pmac_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       marker_found;
   logic [pmac_pkg::CNT_W-1:0] first_offset;
   logic [pmac_pkg::CNT_W-1:0] mismatch_count;
   modport source (output valid, marker_found, first_offset, mismatch_count, input ready);
   modport sink   (input valid, marker_found, first_offset, mismatch_count, output ready);
endinterface

interface pmac_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pmac_pkg::CSR_IDX_W-1:0] index;
   logic [pmac_pkg::WORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pmac_scan_core.sv =====
// scan state and per-word marker check
`default_nettype none

module pmac_scan_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [pmac_pkg::WORD_W-1:0]   sample_word,
   input  logic                          last_word,
   input  logic [pmac_pkg::WORD_W-1:0]   marker_mask,
   input  logic [pmac_pkg::PERIOD_W-1:0] orbit_period,
   output pmac_pkg::result_type          result
);
   import pmac_pkg::*;

   logic                found_ff, found_in;
   logic [CNT_W-1:0]    index_ff, index_in;
   logic [CNT_W-1:0]    offset_ff, offset_in;
   logic [PERIOD_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0]    error_ff, error_in;

   logic [WORD_W-1:0]   masked;
   logic                found_now;
   logic [PERIOD_W-1:0] phase_cur;
   logic [PERIOD_W:0]   phase_inc;
   logic                slot;
   logic                full;
   logic                mismatch;
   logic [CNT_W-1:0]    error_next;
   logic [PERIOD_W-1:0] phase_next;
   logic [CNT_W-1:0]    offset_next;
   logic [CNT_W-1:0]    index_plus;
   logic                scan_end;

   always_comb begin
      masked      = sample_word & marker_mask;
      found_now   = found_ff | (|masked);
      phase_cur   = found_ff ? phase_ff : '0;
      slot        = (phase_cur == '0);
      full        = (masked == marker_mask);
      mismatch    = found_now && (full != slot);
      error_next  = (mismatch && (error_ff != '1)) ? error_ff + CNT_W'(1) : error_ff;
      phase_inc   = {1'b0, phase_cur} + (PERIOD_W + 1)'(1);
      // a period of zero wraps every word, same as a period of one
      phase_next  = (phase_inc >= {1'b0, orbit_period}) ? '0 : phase_inc[PERIOD_W-1:0];
      offset_next = found_ff ? offset_ff : index_ff;
      index_plus  = index_ff + CNT_W'(1);
      scan_end    = last_word || (index_ff >= LAST_INDEX);

      result.done           = scan_end;
      result.marker_found   = found_now;
      result.first_offset   = found_now ? offset_next : index_plus;
      result.mismatch_count = found_now ? error_next : '0;

      found_in  = found_ff;
      index_in  = index_ff;
      offset_in = offset_ff;
      phase_in  = phase_ff;
      error_in  = error_ff;
      if (advance) begin
         if (scan_end) begin
            found_in  = 1'b0;
            index_in  = '0;
            offset_in = '0;
            phase_in  = '0;
            error_in  = '0;
         end else begin
            found_in  = found_now;
            index_in  = index_plus;
            offset_in = offset_next;
            phase_in  = found_now ? phase_next : phase_ff;
            error_in  = error_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         index_ff  <= '0;
         offset_ff <= '0;
         phase_ff  <= '0;
         error_ff  <= '0;
      end else begin
         found_ff  <= found_in;
         index_ff  <= index_in;
         offset_ff <= offset_in;
         phase_ff  <= phase_in;
         error_ff  <= error_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_marker_alignment_check.sv =====
// top level: periodic orbit marker alignment check over a snapshot stream
//
// usage
//  - req_chan carries snapshot words in order; last_word marks the final one.
//    a word at index MAX_WORDS-1 closes the snapshot on its own
//  - rsp_chan gives one transaction per snapshot: found flag, offset of the
//    first marker word (word count if none) and the mismatch count
//  - csr_chan writes marker_mask (index 0) or orbit_period (index 1); it is
//    always ready and is meant to be used only while the block is idle
//  - throughput: one word per cycle while no closing word waits on a held result,
//    set by the single input register and the short scan logic behind it
//  - the last word is registered in the input register, and its result in the
//    result register, which drives rsp_chan
//  - when rsp_chan stalls, the held result stays put while words that do not
//    end a snapshot keep flowing; a second closing word waits in the input
//    register until the held result is taken
//  - reset clears scan state and all valids and restores mask 1, period 3564
`default_nettype none

module periodic_marker_alignment_check (
   input  logic       clock,
   input  logic       reset,
   pmac_req_if.sink   req_chan,
   pmac_rsp_if.source rsp_chan,
   pmac_csr_if.sink   csr_chan
);
   import pmac_pkg::*;

   // configuration registers
   logic [WORD_W-1:0]   mask_ff, mask_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   // input register stage
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff, s1_word_in;
   logic              s1_last_ff, s1_last_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic       req_fire;
   logic       out_free;
   logic       s1_advance;
   logic       rsp_load;
   result_type core_result;

   pmac_scan_core u_scan_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (s1_advance),
      .sample_word  (s1_word_ff),
      .last_word    (s1_last_ff),
      .marker_mask  (mask_ff),
      .orbit_period (period_ff),
      .result       (core_result)
   );

   always_comb begin
      // result slot is free if empty or being drained this cycle
      out_free   = !rsp_valid_ff || rsp_chan.ready;
      // words that close nothing never wait on the result side
      s1_advance = s1_valid_ff && (!core_result.done || out_free);
      rsp_load   = s1_advance && core_result.done;
      req_fire   = req_chan.valid && req_chan.ready;

      s1_valid_in = req_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_word_in  = req_fire ? req_chan.sample_word : s1_word_ff;
      s1_last_in  = req_fire ? req_chan.last_word : s1_last_ff;

      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_found_in  = rsp_load ? core_result.marker_found : rsp_found_ff;
      rsp_offset_in = rsp_load ? core_result.first_offset : rsp_offset_ff;
      rsp_count_in  = rsp_load ? core_result.mismatch_count : rsp_count_ff;

      mask_in   = mask_ff;
      period_in = period_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MARKER_MASK:  mask_in   = csr_chan.data;
            CSR_ORBIT_PERIOD: period_in = csr_chan.data[PERIOD_W-1:0];
            default:          ;
         endcase
      end
   end

   assign req_chan.ready          = !s1_valid_ff || s1_advance;
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.marker_found   = rsp_found_ff;
   assign rsp_chan.first_offset   = rsp_offset_ff;
   assign rsp_chan.mismatch_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= MASK_RESET;
         period_ff    <= PERIOD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
         period_ff    <= period_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_word_ff    <= s1_word_in;
      s1_last_ff    <= s1_last_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pmac_checker.sv =====
// port-level checker for the alignment check block and its bind
`default_nettype none
`include "periodic_marker_alignment_check_macros.svh"

module pmac_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_marker_found,
   input logic [pmac_pkg::CNT_W-1:0] rsp_first_offset,
   input logic [pmac_pkg::CNT_W-1:0] rsp_mismatch_count
);
   import pmac_pkg::*;

   logic             stalled;
   logic             no_marker;
   logic             has_marker;
   logic             missing_offset_ok;
   logic [2*CNT_W:0] rsp_payload;

   assign stalled     = rsp_valid && !rsp_ready;
   assign no_marker   = rsp_valid && !rsp_marker_found;
   assign has_marker  = rsp_valid && rsp_marker_found;
   assign rsp_payload = {rsp_marker_found, rsp_first_offset, rsp_mismatch_count};
   // with no marker the offset is the word count, at least one
   assign missing_offset_ok = (rsp_first_offset != '0) &&
                              (rsp_first_offset <= CNT_W'(MAX_WORDS));

   `PMAC_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid)
   `PMAC_ASSERT_NEXT(a_rsp_stable, clock, reset, stalled, $stable(rsp_payload))
   `PMAC_ASSERT_SAME(a_no_marker_no_count, clock, reset, no_marker, rsp_mismatch_count == '0)
   `PMAC_ASSERT_SAME(a_found_offset_range, clock, reset, has_marker, rsp_first_offset <= LAST_INDEX)
   `PMAC_ASSERT_SAME(a_missing_offset_range, clock, reset, no_marker, missing_offset_ok)

endmodule

bind periodic_marker_alignment_check pmac_checker u_pmac_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_marker_found   (rsp_chan.marker_found),
   .rsp_first_offset   (rsp_chan.first_offset),
   .rsp_mismatch_count (rsp_chan.mismatch_count)
);

`default_nettype wire

// ===== bench/periodic_marker_alignment_check_tb.sv =====
// testbench for periodic_marker_alignment_check: directed and random snapshots, self-checking
`timescale 1ns / 1ps

module periodic_marker_alignment_check_tb;
   import pmac_pkg::*;

   // summary of one finished snapshot, as the block reports it
   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] offset;
      logic [CNT_W-1:0] mismatches;
   } snapshot_summary_type;

   // tracks the scan state of the block and the summaries it still owes
   class marker_scan_tracker;
      logic [WORD_W-1:0]    mask;
      logic [PERIOD_W-1:0]  period;
      logic                 found;
      logic [CNT_W-1:0]     index;
      logic [CNT_W-1:0]     offset;
      logic [PERIOD_W-1:0]  phase;
      logic [CNT_W-1:0]     errors;
      snapshot_summary_type owed_summaries[$];
      int                   fail_count;

      function new();
         mask       = MASK_RESET;
         period     = PERIOD_RESET;
         fail_count = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         found  = 1'b0;
         index  = '0;
         offset = '0;
         phase  = '0;
         errors = '0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
         if (idx == CSR_MARKER_MASK)
            mask = value;
         else if (idx == CSR_ORBIT_PERIOD)
            period = value[PERIOD_W-1:0];
      endfunction

      function void note_word(logic [WORD_W-1:0] w, logic last);
         logic                 full;
         logic                 closes;
         logic [PERIOD_W:0]    next_phase;
         snapshot_summary_type s;
         if (!found && (w & mask) != '0) begin
            found  = 1'b1;
            offset = index;
            phase  = '0;
         end
         if (found) begin
            full = ((w & mask) == mask);
            if ((full != (phase == '0)) && errors != '1)
               errors = errors + 1'b1;
            next_phase = {1'b0, phase} + 1'b1;
            phase = (next_phase >= {1'b0, period}) ? '0 : next_phase[PERIOD_W-1:0];
         end
         closes = last || (index >= LAST_INDEX);
         index  = index + 1'b1;
         if (closes) begin
            s.found      = found;
            s.offset     = found ? offset : index;
            s.mismatches = found ? errors : '0;
            owed_summaries.push_back(s);
            clear_scan();
         end
      endfunction

      function void check_summary(logic f, logic [CNT_W-1:0] o, logic [CNT_W-1:0] m);
         snapshot_summary_type s;
         if (owed_summaries.size() == 0) begin
            $error("unexpected result: marker_found %0d first_offset %0d mismatch_count %0d",
                   f, o, m);
            fail_count++;
            return;
         end
         s = owed_summaries.pop_front();
         if (f !== s.found) begin
            $error("marker_found: expected %0d, actual %0d", s.found, f);
            fail_count++;
         end
         if (o !== s.offset) begin
            $error("first_offset: expected %0d, actual %0d", s.offset, o);
            fail_count++;
         end
         if (m !== s.mismatches) begin
            $error("mismatch_count: expected %0d, actual %0d", s.mismatches, m);
            fail_count++;
         end
      endfunction

      function int owed_count();
         return owed_summaries.size();
      endfunction
   endclass

   localparam int HOLD_CYCLES  = 300;   // length of the long receiver hold-off
   localparam int PHASE_WORDS  = 170;   // words per random phase
   localparam int RANDOM_PHASES = 12;

   logic clock;
   logic reset;

   pmac_req_if req_if ();
   pmac_rsp_if rsp_if ();
   pmac_csr_if csr_if ();

   marker_scan_tracker tracker = new();

   // idle and stall percentages, set per phase by the stimulus process
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   // bumped to ask the receiver for one long hold-off
   int hold_token    = 0;

   periodic_marker_alignment_check dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // hard limit on run time, far above the slowest correct run
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request, counted here
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // result monitor: every accepted result transaction is checked
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_summary(rsp_if.marker_found, rsp_if.first_offset,
                               rsp_if.mismatch_count);
   end

   // offer one word, with random idle cycles in front, and wait for its transaction
   task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.sample_word = w;
      req_if.last_word   = last;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_word(w, last);
   endtask

   // stop offering words, wait for every owed result, then let the pipeline drain
   task automatic wait_until_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (tracker.owed_count() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = value;
      do @(posedge clock); while (!csr_if.ready);
      tracker.write_register(idx, value);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic configure(input logic [WORD_W-1:0] mask, input logic [PERIOD_W-1:0] period);
      wait_until_idle();
      write_register(CSR_MARKER_MASK, mask);
      write_register(CSR_ORBIT_PERIOD, WORD_W'(period));
   endtask

   // one snapshot: marker-free lead-in, then the periodic pattern with optional flaws
   task automatic send_snapshot(input int len, input int lead, input int flaw_pct,
                                input bit close);
      logic [WORD_W-1:0] m;
      logic [WORD_W-1:0] w;
      int                per;
      m   = tracker.mask;
      per = (tracker.period == 0) ? 1 : int'(tracker.period);
      for (int i = 0; i < len; i++) begin
         if (i < lead)
            w = $urandom & ~m;
         else if (((i - lead) % per) == 0)
            w = $urandom | m;
         else
            w = $urandom & ~m;
         if ($urandom_range(99) < flaw_pct)
            w = $urandom;
         send_word(w, close && (i == len - 1));
      end
   endtask

   task automatic run_random_phase(input int ph);
      logic [WORD_W-1:0]   mask;
      logic [PERIOD_W-1:0] period;
      int                  words;
      int                  len;
      int                  lead;
      int                  flaw;
      bit                  final_one;
      // first phases hit the register extremes, the rest draw at random
      case (ph)
         0: begin mask = '1;            period = 16'd1;    end
         1: begin mask = '0;            period = 16'hFFFF; end
         2: begin mask = 32'h8000_0000; period = 16'd0;    end
         default: begin
            case ($urandom_range(3))
               0: mask = 32'h1 << $urandom_range(31);
               1: mask = $urandom;
               2: mask = $urandom & $urandom;
               default: mask = ~(32'h1 << $urandom_range(31));
            endcase
            case ($urandom_range(7))
               0: period = 16'd0;
               1: period = 16'hFFFF;
               default: period = PERIOD_W'($urandom_range(1, 9));
            endcase
         end
      endcase
      configure(mask, period);

      // idling mode rotates: none, sender idle, receiver stall, both
      case (ph % 4)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 54; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 54; end
         default: begin req_idle_pct = 35; rsp_stall_pct = 35; end
      endcase
      // long receiver hold-off while words keep coming, so the block backs up
      if (ph == 4)
         hold_token++;

      words = 0;
      while (words < PHASE_WORDS) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         lead = ($urandom_range(7) == 0) ? $urandom_range(0, len) : $urandom_range(0, 3);
         case ($urandom_range(19))
            0, 1, 2:       flaw = 50;
            3, 4, 5, 6, 7: flaw = 5;
            default:       flaw = 0;
         endcase
         final_one = (words + len >= PHASE_WORDS);
         // the last snapshot of a phase is sometimes left open across the next setting
         send_snapshot(len, lead, flaw, !final_one || ($urandom_range(3) != 0));
         words += len;
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.sample_word = '0;
      req_if.last_word   = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_MARKER_MASK;
      csr_if.data        = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, all-ones word and a marker after two empty words
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h0, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h1, 1'b1);

      // full mask, period one: partial marker first, then a missing slot
      configure(32'hFFFF_FFFF, 16'd1);
      send_word(32'h1, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);

      // zero period acts as one
      configure(32'h8000_0001, 16'd0);
      send_word(32'h8000_0001, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h8000_0001, 1'b1);

      // zero mask: nothing can ever be found, offset is the word count
      configure(32'h0, 16'hFFFF);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);

      // period change in the middle of an open snapshot
      configure(32'h3, 16'd3);
      send_word(32'h0, 1'b0);
      send_word(32'h3, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h2, 1'b0);
      send_word(32'h3, 1'b0);
      wait_until_idle();
      write_register(CSR_ORBIT_PERIOD, 32'd2);
      send_word(32'h0, 1'b0);
      send_word(32'h3, 1'b0);
      send_word(32'h0, 1'b1);

      // random phases
      for (int ph = 0; ph < RANDOM_PHASES; ph++)
         run_random_phase(ph);

      // close whatever the last phase left open, under a new setting
      configure(32'h0000_0100, 16'd7);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_snapshot(5, 1, 0, 1'b1);

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (tracker.fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
